// ----- src/bed_pkg.sv -----
package bed_pkg;

  // Default longest pattern or query string
  localparam int DEF_MAX_LEN = 64;

  // Field and register widths
  localparam int SYM_W   = 32;
  localparam int THR_W   = 7;
  localparam int DIST_W  = 7;
  // Cell costs are capped at threshold + 1, which needs one more bit than threshold
  localparam int COST_W  = THR_W + 1;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register map: word index taken from paddr[PADDR_W-1:2]
  localparam logic [PADDR_W-3:0] REG_THRESHOLD = '0;
  localparam logic [THR_W-1:0]   THR_RESET     = THR_W'(1);

  // Input item kinds
  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_HOLD
  } state_t;

  // Wavefront handed from cell to cell: new cost of the column to the left,
  // its old cost (diagonal) and the running row minimum
  typedef struct packed {
    logic              vld;
    logic [COST_W-1:0] left;
    logic [COST_W-1:0] diag;
    logic [COST_W-1:0] rmin;
  } wave_t;

  // Row settings broadcast to all cells, held for one sweep
  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [COST_W-1:0] limit;
    logic              first;
  } row_ctl_t;

  // Width of a length or count that must hold MAX_LEN + 1
  function automatic int len_w(input int max_len);
    return $clog2(max_len + 2);
  endfunction

  // Width for sums of a length and the threshold
  function automatic int ext_w(input int max_len);
    int lw;
    lw = $clog2(max_len + 2);
    return ((lw > THR_W) ? lw : THR_W) + 1;
  endfunction

  function automatic logic [COST_W-1:0] cost_min(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ----- src/bounded_edit_distance.sv -----
// Bounded edit distance. Load a pattern with kind = 0 beats (last_of_string on its
// final symbol), then stream a query with kind = 1 beats. Each query symbol computes one
// banded row of Levenshtein costs in a row of MAX_LEN cells, one cell per pattern
// column: the row enters as a wavefront that moves one cell per cycle. A pattern beat
// is taken at once. A query beat that runs a row stalls input until the wavefront leaves
// the row and any result it delivers is loaded; one rejected up front (too long, or
// length difference above threshold) stalls until its result is loaded, and one after
// the query has already reported does not. At most one result per query: early
// exceeded, too_long, or the distance on the last symbol. Write threshold only while idle.
module bounded_edit_distance import bed_pkg::*; #(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               kind,
  input  logic [SYM_W-1:0]   symbol,
  input  logic               last_of_string,
  // results
  output logic               result_valid,
  input  logic               result_stall,
  output logic [DIST_W-1:0]  distance,
  output logic               exceeded,
  output logic               too_long,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int EW = ext_w(MAX_LEN);
  localparam int AW = $clog2(MAX_LEN);

  logic [THR_W-1:0]  threshold;
  logic              reg_wr;
  logic [PADDR_W-3:0] reg_idx;

  logic              pat_we;
  logic [AW-1:0]     pat_addr;
  logic [SYM_W-1:0]  pat_data;
  row_ctl_t          ctl;
  logic [EW-1:0]     lo;
  logic [EW-1:0]     stop;
  logic [EW-1:0]     m;
  wave_t             chain [0:MAX_LEN];

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (reg_wr && reg_idx == REG_THRESHOLD) begin
      threshold <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_THRESHOLD) begin
      prdata = PDATA_W'(threshold);
    end
  end

  // Sequencer
  bed_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .threshold      (threshold),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .kind           (kind),
    .symbol         (symbol),
    .last_of_string (last_of_string),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .distance       (distance),
    .exceeded       (exceeded),
    .too_long       (too_long),
    .pat_we         (pat_we),
    .pat_addr       (pat_addr),
    .pat_data       (pat_data),
    .ctl            (ctl),
    .lo             (lo),
    .stop           (stop),
    .m              (m),
    .inject         (chain[0]),
    .chain_out      (chain[MAX_LEN])
  );

  // Row of cells, one per pattern column
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    bed_cell #(
      .MAX_LEN (MAX_LEN),
      .IDX     (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .pat_we   (pat_we),
      .pat_addr (pat_addr),
      .pat_data (pat_data),
      .ctl      (ctl),
      .lo       (lo),
      .stop     (stop),
      .m        (m),
      .wave_in  (chain[k]),
      .wave_out (chain[k+1])
    );
  end

endmodule

// ----- src/bed_cell.sv -----
module bed_cell import bed_pkg::*; #(
  parameter int MAX_LEN = DEF_MAX_LEN,
  parameter int IDX     = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pat_we,
  input  logic [$clog2(MAX_LEN)-1:0]  pat_addr,
  input  logic [SYM_W-1:0]            pat_data,
  input  row_ctl_t                    ctl,
  input  logic [ext_w(MAX_LEN)-1:0]   lo,
  input  logic [ext_w(MAX_LEN)-1:0]   stop,
  input  logic [ext_w(MAX_LEN)-1:0]   m,
  input  wave_t                       wave_in,
  output wave_t                       wave_out
);

  localparam int EW = ext_w(MAX_LEN);
  localparam int AW = $clog2(MAX_LEN);
  localparam logic [EW-1:0] COL = EW'(IDX + 1);

  logic [SYM_W-1:0]  pat;
  logic [COST_W-1:0] cost;
  logic [COST_W-1:0] col_cap;
  logic [COST_W-1:0] old;
  logic [COST_W-1:0] up;
  logic [COST_W-1:0] sub;
  logic [COST_W-1:0] v;
  logic [COST_W-1:0] newc;
  logic              active;
  logic              in_band;
  wave_t             wave_nx;

  // Pattern symbol of this column
  always_ff @(posedge clk) begin
    if (pat_we && pat_addr == AW'(IDX)) begin
      pat <= pat_data;
    end
  end

  // One edit-cost cell of the banded row
  always_comb begin
    col_cap = (COL > EW'(ctl.limit)) ? ctl.limit : COL[COST_W-1:0];
    old     = ctl.first ? col_cap : cost;
    active  = (COL <= m);
    in_band = (COL >= lo) && (COL <= stop);
    up      = cost_min(old, wave_in.left) + COST_W'(1);
    sub     = (ctl.sym != pat) ? wave_in.diag + COST_W'(1) : wave_in.diag;
    v       = in_band ? cost_min(up, sub) : ctl.limit;
    newc    = cost_min(v, ctl.limit);
    wave_nx = wave_in;
    if (active) begin
      wave_nx.left = newc;
      wave_nx.diag = old;
      wave_nx.rmin = cost_min(wave_in.rmin, newc);
    end
  end

  // Keep the new cost for the next row
  always_ff @(posedge clk) begin
    if (wave_in.vld && active) begin
      cost <= newc;
    end
  end

  // Hand the wavefront to the next column
  always_ff @(posedge clk) begin
    wave_out <= wave_nx;
    if (rst) begin
      wave_out.vld <= 1'b0;
    end
  end

endmodule

// ----- src/bed_ctrl.sv -----
module bed_ctrl import bed_pkg::*; #(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [THR_W-1:0]            threshold,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        kind,
  input  logic [SYM_W-1:0]            symbol,
  input  logic                        last_of_string,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [DIST_W-1:0]           distance,
  output logic                        exceeded,
  output logic                        too_long,
  output logic                        pat_we,
  output logic [$clog2(MAX_LEN)-1:0]  pat_addr,
  output logic [SYM_W-1:0]            pat_data,
  output row_ctl_t                    ctl,
  output logic [ext_w(MAX_LEN)-1:0]   lo,
  output logic [ext_w(MAX_LEN)-1:0]   stop,
  output logic [ext_w(MAX_LEN)-1:0]   m,
  output wave_t                       inject,
  input  wave_t                       chain_out
);

  localparam int LW = len_w(MAX_LEN);
  localparam int EW = ext_w(MAX_LEN);
  localparam int AW = $clog2(MAX_LEN);

  state_t state;
  state_t state_next;

  // Control state
  logic [LW-1:0]     pat_len;
  logic              ovf;
  logic              loading;
  logic [LW-1:0]     qcnt;
  logic              exc_flag;
  logic              inj_vld;

  // Row and result payload
  logic [COST_W-1:0] inj_left;
  logic [COST_W-1:0] inj_diag;
  logic [COST_W-1:0] row0;
  logic [THR_W-1:0]  cur_t;
  logic [EW-1:0]     cur_n;
  logic              cur_last;
  logic [DIST_W-1:0] pend_dist;
  logic              pend_exc;
  logic              pend_long;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic              is_query;

  // Pattern path
  logic [LW-1:0]     len_eff;
  logic              ovf_eff;

  // Query path
  logic [COST_W-1:0] limit;
  logic              first;
  logic              exc_eff;
  logic [LW-1:0]     n;
  logic [EW-1:0]     n_ext;
  logic [EW-1:0]     t_ext;
  logic [EW-1:0]     i_ext;
  logic [EW-1:0]     ipt;
  logic [EW-1:0]     lo_q;
  logic [EW-1:0]     stop_q;
  logic [EW-1:0]     r0_full;
  logic [COST_W-1:0] row0_new;
  logic [COST_W-1:0] row0_old;
  logic              too_long_hit;
  logic              len_hit;
  logic              do_sweep;
  logic              early_emit;

  // End of sweep
  logic              rmin_hit;
  logic              late_hit;
  logic              emit_end;
  logic              end_exc;
  logic [DIST_W-1:0] end_dist;

  assign accept   = item_valid && !item_stall;
  assign is_query = (kind == KIND_QUERY);
  assign out_free = !result_valid || !result_stall;
  assign m        = EW'(pat_len);
  assign inject   = '{vld: inj_vld, left: inj_left, diag: inj_diag, rmin: inj_left};

  // Pattern store write: a new pattern restarts at column zero
  always_comb begin
    len_eff  = loading ? pat_len : '0;
    ovf_eff  = loading && ovf;
    pat_we   = accept && !is_query && (len_eff < LW'(MAX_LEN));
    pat_addr = len_eff[AW-1:0];
    pat_data = symbol;
  end

  // Query symbol: checks and band limits of the new row
  always_comb begin
    limit        = COST_W'(threshold) + COST_W'(1);
    first        = (qcnt == '0);
    exc_eff      = !first && exc_flag;
    n            = (qcnt <= LW'(MAX_LEN)) ? qcnt + LW'(1) : qcnt;
    n_ext        = EW'(n);
    t_ext        = EW'(threshold);
    i_ext        = EW'(qcnt);
    too_long_hit = ovf || (n_ext > EW'(MAX_LEN));
    len_hit      = n_ext > m + t_ext;
    do_sweep     = !exc_eff && !too_long_hit && !len_hit;
    early_emit   = !exc_eff && (too_long_hit || len_hit);
    lo_q         = (i_ext > t_ext) ? i_ext - t_ext : '0;
    ipt          = i_ext + t_ext;
    stop_q       = (ipt < m) ? ipt : m;
    r0_full      = i_ext + EW'(1);
    row0_new     = (r0_full > EW'(limit)) ? limit : r0_full[COST_W-1:0];
    row0_old     = first ? '0 : row0;
  end

  // Row finished: early exceed on the row minimum, final check on the last symbol
  always_comb begin
    rmin_hit = chain_out.rmin > COST_W'(cur_t);
    late_hit = (m > cur_n + EW'(cur_t)) || (chain_out.left > COST_W'(cur_t));
    emit_end = rmin_hit || cur_last;
    end_exc  = rmin_hit || late_hit;
    end_dist = end_exc ? '0 : chain_out.left[DIST_W-1:0];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid && is_query) begin
          if (do_sweep) begin
            state_next = ST_SWEEP;
          end else if (early_emit) begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_SWEEP: begin
        if (chain_out.vld) begin
          state_next = emit_end ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len      <= '0;
      ovf          <= 1'b0;
      loading      <= 1'b1;
      qcnt         <= '0;
      exc_flag     <= 1'b0;
      inj_vld      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      inj_vld <= accept && is_query && do_sweep;
      if (accept) begin
        if (!is_query) begin
          loading  <= !last_of_string;
          qcnt     <= '0;
          exc_flag <= 1'b0;
          pat_len  <= pat_we ? len_eff + LW'(1) : len_eff;
          ovf      <= pat_we ? ovf_eff : 1'b1;
        end else begin
          loading <= 1'b0;
          qcnt    <= last_of_string ? '0 : n;
          if (!do_sweep) begin
            exc_flag <= !last_of_string && (exc_eff || early_emit);
          end
        end
      end
      if (state == ST_SWEEP && chain_out.vld) begin
        exc_flag <= !cur_last && emit_end;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Row settings, pending result and output beat
  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      if (do_sweep) begin
        ctl      <= '{sym: symbol, limit: limit, first: first};
        lo       <= lo_q;
        stop     <= stop_q;
        cur_t    <= threshold;
        cur_n    <= n_ext;
        cur_last <= last_of_string;
        inj_left <= row0_new;
        inj_diag <= row0_old;
        row0     <= row0_new;
      end
      pend_dist <= '0;
      pend_exc  <= !too_long_hit;
      pend_long <= too_long_hit;
    end
    if (state == ST_SWEEP && chain_out.vld) begin
      pend_dist <= end_dist;
      pend_exc  <= end_exc;
      pend_long <= 1'b0;
    end
    if (out_load) begin
      distance <= pend_dist;
      exceeded <= pend_exc;
      too_long <= pend_long;
    end
  end

  // The wavefront reaches the end of the row only during a sweep
  a_wave_in_sweep: assert property (@(posedge clk) disable iff (rst)
    chain_out.vld |-> state == ST_SWEEP)
    else $error("wavefront left the cell row outside a sweep");

  a_inject_once: assert property (@(posedge clk) disable iff (rst)
    inj_vld |=> !inj_vld && state == ST_SWEEP)
    else $error("row injected twice or outside a sweep");

  a_count_bounds: assert property (@(posedge clk) disable iff (rst)
    qcnt <= LW'(MAX_LEN + 1) && pat_len <= LW'(MAX_LEN))
    else $error("query count or pattern length out of range");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(exceeded && too_long) &&
                     ((!exceeded && !too_long) || distance == '0))
    else $error("result flags inconsistent");

endmodule

// ----- verif/edit_distance_checker.sv -----
`timescale 1ns / 1ps

// Watches both beat channels and the register port of the bounded edit distance block,
// predicts every result from the accepted beats and compares it with what comes out.
module edit_distance_checker import bed_pkg::*; #(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  logic               kind,
  input  logic [SYM_W-1:0]   symbol,
  input  logic               last_of_string,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic [DIST_W-1:0]  distance,
  input  logic               exceeded,
  input  logic               too_long,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 fail_count,
  output int                 pending,
  output int                 live_beats
);

  typedef struct packed {
    logic [DIST_W-1:0] edit_dist;
    logic              exc;
    logic              lng;
  } dist_result_t;

  dist_result_t pending_distances[$];
  dist_result_t want;

  // Shadow of the block: stored pattern, banded cost row, query progress
  logic [SYM_W-1:0] pat_mem [MAX_LEN];
  int pat_len;
  int q_len;
  int thr;
  int costs [MAX_LEN+1];
  bit loading;
  bit reported;
  bit pat_ovf;
  int fails = 0;
  int live = 0;

  function automatic int cap(input int v, input int lim);
    return (v > lim) ? lim : v;
  endfunction

  // Advance the shadow by one accepted beat; queue the result it causes, if any
  function automatic void apply_symbol(input logic k, input logic [SYM_W-1:0] s,
                                       input logic l);
    int t, lim, m, n, i, j, lo, start, stop, diag, old, v, sub, rmin;
    bit hit;
    dist_result_t r;
    t = thr;
    lim = t + 1;
    hit = 1'b0;
    r = '0;
    if (k == KIND_PATTERN) begin
      // a pattern beat after a closed pattern starts a fresh one
      if (!loading) begin
        loading = 1'b1;
        pat_len = 0;
        pat_ovf = 1'b0;
      end
      q_len = 0;
      reported = 1'b0;
      if (pat_len < MAX_LEN) begin
        pat_mem[pat_len] = s;
        pat_len++;
      end else begin
        pat_ovf = 1'b1;
      end
      if (l) loading = 1'b0;
      live++;
      return;
    end

    loading = 1'b0;
    m = pat_len;
    if (q_len == 0) begin
      for (j = 0; j <= m; j++) costs[j] = cap(j, lim);
      reported = 1'b0;
    end
    if (!reported) live++;
    if (q_len <= MAX_LEN) q_len++;
    n = q_len;

    if (!reported) begin
      if (pat_ovf || n > MAX_LEN) begin
        r.lng = 1'b1;
        hit = 1'b1;
      end else if (n > m + t) begin
        r.exc = 1'b1;
        hit = 1'b1;
      end else begin
        // one banded row; cells outside the band sit at the cap
        i = n - 1;
        lo = (i > t) ? i - t : 0;
        start = (lo < 1) ? 1 : lo;
        stop = (m < i + t) ? m : i + t;
        diag = costs[0];
        costs[0] = cap(i + 1, lim);
        rmin = costs[0];
        for (j = 1; j <= m; j++) begin
          old = costs[j];
          v = lim;
          if (j >= start && j <= stop) begin
            v = ((old < costs[j-1]) ? old : costs[j-1]) + 1;
            sub = (s != pat_mem[j-1]) ? 1 : 0;
            if (diag + sub < v) v = diag + sub;
          end
          costs[j] = cap(v, lim);
          if (costs[j] < rmin) rmin = costs[j];
          diag = old;
        end
        if (rmin > t) begin
          r.exc = 1'b1;
          hit = 1'b1;
        end else if (l) begin
          hit = 1'b1;
          if (m > n + t || costs[m] > t) r.exc = 1'b1;
          else r.edit_dist = DIST_W'(costs[m]);
        end
      end
    end

    if (hit) begin
      pending_distances.push_back(r);
      reported = 1'b1;
    end
    if (l) begin
      q_len = 0;
      reported = 1'b0;
    end
  endfunction

  // Snoop register writes, predict on input beats, check output beats
  always @(posedge clk) begin
    if (rst) begin
      thr = int'(THR_RESET);
      pat_len = 0;
      q_len = 0;
      loading = 1'b1;
      reported = 1'b0;
      pat_ovf = 1'b0;
      pending_distances.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_THRESHOLD)
        thr = int'(pwdata[THR_W-1:0]);
      if (item_valid && !item_stall)
        apply_symbol(kind, symbol, last_of_string);
      if (result_valid && !result_stall) begin
        if (pending_distances.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: distance %0d exceeded %0b too_long %0b",
                   $time, distance, exceeded, too_long);
        end else begin
          want = pending_distances.pop_front();
          if (want.edit_dist !== distance || want.exc !== exceeded ||
              want.lng !== too_long) begin
            fails++;
            $display("%0t: mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     $time, want.edit_dist, want.exc, want.lng,
                     distance, exceeded, too_long);
          end
        end
      end
    end
    pending <= pending_distances.size();
    fail_count <= fails;
    live_beats <= live;
  end

endmodule

// ----- verif/bounded_edit_distance_tb.sv -----
`timescale 1ns / 1ps

module bounded_edit_distance_tb import bed_pkg::*;;

  localparam int MAX_LEN     = DEF_MAX_LEN;
  localparam int TARGET_BEATS = 1850;
  localparam int ROW_DRAIN   = 100;   // > one row sweep plus loading its result
  localparam int HOLD_CYCLES = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic               kind = KIND_PATTERN;
  logic [SYM_W-1:0]   symbol = '0;
  logic               last_of_string = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [DIST_W-1:0]  distance;
  logic               exceeded;
  logic               too_long;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int pending;
  int live_beats;

  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit long_hold = 1'b0;
  int thr_now = int'(THR_RESET);
  logic [SYM_W-1:0] sym_base = '0;
  int alpha = 4;
  logic [SYM_W-1:0] pat_syms[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_edit_distance #(.MAX_LEN(MAX_LEN)) uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .kind(kind), .symbol(symbol),
    .last_of_string(last_of_string),
    .result_valid(result_valid), .result_stall(result_stall), .distance(distance),
    .exceeded(exceeded), .too_long(too_long),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  edit_distance_checker #(.MAX_LEN(MAX_LEN)) chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .kind(kind), .symbol(symbol),
    .last_of_string(last_of_string),
    .result_valid(result_valid), .result_stall(result_stall), .distance(distance),
    .exceeded(exceeded), .too_long(too_long),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending), .live_beats(live_beats)
  );

  // Offer one beat after a random gap, hold it until taken
  task automatic send_beat(input logic k, input logic [SYM_W-1:0] s, input logic l);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    symbol <= s;
    last_of_string <= l;
    do @(posedge clk); while (item_stall);
  endtask

  // Stop sending until every predicted result is out and the last row has swept
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (ROW_DRAIN) @(posedge clk);
  endtask

  task automatic write_threshold(input int v);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_THRESHOLD, 2'b00};
    pwdata <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    thr_now = v;
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol();
    return sym_base | SYM_W'($urandom_range(0, alpha - 1));
  endfunction

  // Fresh alphabet, then a pattern; an unclosed one gets closed by the next query
  task automatic load_pattern(input int plen, input bit close);
    int i;
    logic [SYM_W-1:0] s;
    sym_base = $urandom() & 32'hFFFF_FFF0;
    alpha = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(1, 4);
    pat_syms.delete();
    for (i = 0; i < plen; i++) begin
      s = pick_symbol();
      if (i < MAX_LEN) pat_syms.push_back(s);
      send_beat(KIND_PATTERN, s, close && (i == plen - 1));
    end
  endtask

  // Mostly an edited copy of the pattern, near the threshold
  task automatic run_query(input bit overlong);
    logic [SYM_W-1:0] q[$];
    int r, k, op, n, i;
    bit drop_last;
    r = $urandom_range(0, 99);
    q = pat_syms;
    if (overlong) begin
      n = MAX_LEN + 1 + $urandom_range(0, 2);
      while (q.size() < n) q.push_back(pick_symbol());
    end else if (r < 10) begin
      q.delete();
      repeat ($urandom_range(1, 12)) q.push_back(pick_symbol());
    end else begin
      k = $urandom_range(0, (thr_now + 2 < 20) ? thr_now + 2 : 20);
      repeat (k) begin
        op = $urandom_range(0, 2);
        if (op == 0 && q.size() > 0)
          q[$urandom_range(0, q.size() - 1)] = pick_symbol();
        else if (op == 1)
          q.insert($urandom_range(0, q.size()), pick_symbol());
        else if (q.size() > 1)
          q.delete($urandom_range(0, q.size() - 1));
      end
    end
    if (q.size() == 0) q.push_back(pick_symbol());
    while (!overlong && q.size() > MAX_LEN) q.delete(q.size() - 1);
    // now and then the query runs on into the next one or is cut by a pattern
    drop_last = !overlong && r >= 97;
    for (i = 0; i < q.size(); i++)
      send_beat(KIND_QUERY, q[i], (i == q.size() - 1) && !drop_last);
  endtask

  // Result side: random stall per beat, plus one long hold on request
  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = rx_gaps ? $urandom_range(0, 15) : 0;
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid && !long_hold);
    end
  end

  initial begin
    #15_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int ph, g, r, t, plen;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty pattern right after reset, threshold at its reset value
    send_beat(KIND_QUERY, 32'h0000_0041, 1'b1);
    send_beat(KIND_QUERY, 32'h0000_0041, 1'b0);
    send_beat(KIND_QUERY, 32'h0000_0042, 1'b1);
    // extreme symbols; exact match, one substitution
    send_beat(KIND_PATTERN, 32'h0000_0000, 1'b0);
    send_beat(KIND_PATTERN, 32'hFFFF_FFFF, 1'b0);
    send_beat(KIND_PATTERN, 32'h0000_0005, 1'b1);
    send_beat(KIND_QUERY, 32'h0000_0000, 1'b0);
    send_beat(KIND_QUERY, 32'hFFFF_FFFF, 1'b0);
    send_beat(KIND_QUERY, 32'h0000_0005, 1'b1);
    send_beat(KIND_QUERY, 32'h0000_0000, 1'b0);
    send_beat(KIND_QUERY, 32'h0000_0007, 1'b0);
    send_beat(KIND_QUERY, 32'h0000_0005, 1'b1);
    // pattern longer than query by more than threshold: caught at the last symbol
    send_beat(KIND_QUERY, 32'h0000_0000, 1'b1);
    // row minimum passes threshold early; the rest of the query is silent
    repeat (3) send_beat(KIND_QUERY, 32'h0000_0009, 1'b0);
    send_beat(KIND_QUERY, 32'h0000_0009, 1'b1);
    // query while the pattern is still open
    send_beat(KIND_PATTERN, 32'h0000_0000, 1'b0);
    send_beat(KIND_PATTERN, 32'h0000_0000, 1'b0);
    send_beat(KIND_QUERY, 32'h0000_0000, 1'b0);
    send_beat(KIND_QUERY, 32'h0000_0000, 1'b1);
    // pattern beat abandons a query in progress
    send_beat(KIND_QUERY, 32'h0000_0003, 1'b0);
    send_beat(KIND_PATTERN, 32'h0000_0003, 1'b1);
    send_beat(KIND_QUERY, 32'h0000_0003, 1'b1);

    // back-pressure: result side holds off while one-symbol queries pile up
    write_threshold(2);
    tx_gaps = 1'b0;
    load_pattern(3, 1'b1);
    long_hold = 1'b1;
    repeat (30) send_beat(KIND_QUERY, pick_symbol(), 1'b1);

    // random phases, each at its own threshold and idling mix
    ph = 0;
    while (live_beats < TARGET_BEATS) begin
      if (ph == 0) begin
        t = 0;
      end else if (ph == 1) begin
        t = 64;
      end else begin
        r = $urandom_range(0, 9);
        t = (r < 4) ? $urandom_range(0, 4) : (r < 8) ? $urandom_range(5, 12) :
            $urandom_range(13, 64);
      end
      write_threshold(t);
      tx_gaps = $urandom_range(0, 2) != 0;
      rx_gaps = $urandom_range(0, 2) != 0;
      for (g = 0; g < $urandom_range(2, 5); g++) begin
        r = $urandom_range(0, 99);
        if ((g == 0 && ph == 1) || r < 2) plen = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
        else if (r < 10) plen = $urandom_range(41, MAX_LEN);
        else if (r < 30) plen = $urandom_range(11, 40);
        else plen = $urandom_range(1, 10);
        load_pattern(plen, $urandom_range(0, 19) != 0);
        repeat ($urandom_range(1, 4))
          run_query((g == 0 && ph == 2) || $urandom_range(0, 39) == 0);
      end
      ph++;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/bed_pkg.sv
src/bed_cell.sv
src/bed_ctrl.sv
src/bounded_edit_distance.sv
verif/edit_distance_checker.sv
verif/bounded_edit_distance_tb.sv
